@@ hw/rtl/oahs_pkg.sv @@
// ----------------------------------------------------------------------------
// oahs_pkg
// Shared types and constants of the open-addressing hash set.
// ----------------------------------------------------------------------------
`default_nettype none

package oahs_pkg;

    localparam int KEY_W         = 64;
    localparam int ACT_W         = 2;
    localparam int CNT_OUT_W     = 11;
    localparam int OUT_TDATA_W   = 24;
    localparam int MOD_STEP_BITS = 4;
    localparam int MOD_DIGITS    = KEY_W / MOD_STEP_BITS;
    localparam int MOD_DIG_W     = $clog2(MOD_DIGITS);
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 64;

    localparam logic [KEY_W-1:0] TOMB_MARK        = 64'hdeaddeaddeaddead;
    localparam logic [KEY_W-1:0] ZERO_SUB_DEFAULT = 64'd1;
    localparam logic [KEY_W-1:0] MARK_SUB_DEFAULT = 64'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD      = 2'd0,
        ACT_REMOVE   = 2'd1,
        ACT_CONTAINS = 2'd2,
        ACT_CLEAR    = 2'd3
    } t_action;

    typedef struct packed {
        t_action            action;
        logic [KEY_W-1:0]   key;
    } t_req;

endpackage

`default_nettype wire

@@ hw/rtl/oahs_queue.sv @@
// ----------------------------------------------------------------------------
// oahs_queue
// Small request queue between the front end and the probe engine.
// ----------------------------------------------------------------------------
`default_nettype none

module oahs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/oahs_front.sv @@
// ----------------------------------------------------------------------------
// oahs_front
// Accepts requests, substitutes reserved keys and works out the home slot.
// ----------------------------------------------------------------------------
`default_nettype none

module oahs_front #(
    parameter int TABLE_SLOTS = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_init_busy,
    input  wire logic [oahs_pkg::KEY_W-1:0]    i_zero_sub,
    input  wire logic [oahs_pkg::KEY_W-1:0]    i_mark_sub,
    input  wire logic                          i_tvalid,
    output logic                               o_tready,
    input  wire logic [oahs_pkg::KEY_W-1:0]    i_key,
    input  wire logic [oahs_pkg::ACT_W-1:0]    i_action,
    output logic                               o_push,
    input  wire logic                          i_q_full,
    output oahs_pkg::t_req                     o_req,
    output logic [$clog2(TABLE_SLOTS)-1:0]     o_home
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam logic [IW:0] SLOTS_W = (IW + 1)'(TABLE_SLOTS);
    localparam logic [oahs_pkg::MOD_DIG_W-1:0] DIG_LAST =
        oahs_pkg::MOD_DIG_W'(oahs_pkg::MOD_DIGITS - 1);

    typedef enum logic [1:0] {F_IDLE, F_MOD, F_PUSH} t_fstate;

    t_fstate                            r_state, n_state;
    oahs_pkg::t_action                  r_action, n_action;
    logic [oahs_pkg::KEY_W-1:0]         r_key, n_key;
    logic [oahs_pkg::KEY_W-1:0]         r_shift, n_shift;
    logic [IW-1:0]                      r_rem, n_rem;
    logic [oahs_pkg::MOD_DIG_W-1:0]     r_dig, n_dig;
    logic [oahs_pkg::KEY_W-1:0]         sub_key;
    logic [oahs_pkg::KEY_W-1:0]         step_shift;
    logic [IW-1:0]                      step_rem;
    logic                               accept;

    always_comb begin
        sub_key = i_key;
        if (i_key == '0) begin
            sub_key = i_zero_sub;
            if (i_zero_sub == '0 || i_zero_sub == oahs_pkg::TOMB_MARK) begin
                sub_key = oahs_pkg::ZERO_SUB_DEFAULT;
            end
        end else if (i_key == oahs_pkg::TOMB_MARK) begin
            sub_key = i_mark_sub;
            if (i_mark_sub == '0 || i_mark_sub == oahs_pkg::TOMB_MARK) begin
                sub_key = oahs_pkg::MARK_SUB_DEFAULT;
            end
        end
    end

    // four key bits a cycle, most significant key bit first
    always_comb begin
        logic [IW:0] t;
        step_rem   = r_rem;
        step_shift = r_shift;
        for (int j = 0; j < oahs_pkg::MOD_STEP_BITS; j++) begin
            t = {step_rem, step_shift[oahs_pkg::KEY_W-1]};
            step_shift = {step_shift[oahs_pkg::KEY_W-2:0], 1'b0};
            if (t >= SLOTS_W) begin
                t = t - SLOTS_W;
            end
            step_rem = t[IW-1:0];
        end
    end

    assign o_tready = (r_state == F_IDLE) && !i_init_busy;
    assign accept   = i_tvalid && o_tready;
    assign o_push   = (r_state == F_PUSH);
    assign o_req    = '{action: r_action, key: r_key};
    assign o_home   = r_rem;

    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        n_key    = r_key;
        n_shift  = r_shift;
        n_rem    = r_rem;
        n_dig    = r_dig;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_action = oahs_pkg::t_action'(i_action);
                    n_key    = sub_key;
                    n_dig    = '0;
                    if (IS_POW2) begin
                        n_rem   = sub_key[IW-1:0];
                        n_state = F_PUSH;
                    end else begin
                        n_rem   = '0;
                        n_shift = sub_key;
                        n_state = F_MOD;
                    end
                end
            end
            F_MOD: begin
                n_rem   = step_rem;
                n_shift = step_shift;
                n_dig   = r_dig + oahs_pkg::MOD_DIG_W'(1);
                if (r_dig == DIG_LAST) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_action <= n_action;
        r_key    <= n_key;
        r_shift  <= n_shift;
        r_rem    <= n_rem;
        r_dig    <= n_dig;
    end

endmodule

`default_nettype wire

@@ hw/rtl/oahs_back.sv @@
// ----------------------------------------------------------------------------
// oahs_back
// Probe engine: slot store, quadratic probing, counts and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module oahs_back #(
    parameter int TABLE_SLOTS = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    output logic                                   o_init_busy,
    input  wire logic                              i_q_valid,
    input  wire oahs_pkg::t_req                    i_q_req,
    input  wire logic [$clog2(TABLE_SLOTS)-1:0]    i_q_home,
    output logic                                   o_q_pop,
    output logic                                   o_tvalid,
    input  wire logic                              i_tready,
    output logic [oahs_pkg::OUT_TDATA_W-1:0]       o_tdata
);

    localparam int IW   = $clog2(TABLE_SLOTS);
    localparam int CW0  = $clog2(TABLE_SLOTS + 1);
    localparam int CNTW = (CW0 > oahs_pkg::CNT_OUT_W) ? CW0 : oahs_pkg::CNT_OUT_W;
    localparam logic [IW:0]     SLOTS_W  = (IW + 1)'(TABLE_SLOTS);
    localparam logic [IW-1:0]   LAST_IDX = IW'(TABLE_SLOTS - 1);
    localparam logic [CNTW:0]   SLOTS_C  = (CNTW + 1)'(TABLE_SLOTS);

    typedef enum logic [2:0] {B_INIT, B_IDLE, B_SWEEP, B_RD, B_CHK, B_DONE} t_bstate;

    function automatic logic [IW-1:0] addmod(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SLOTS_W) begin
            s = s - SLOTS_W;
        end
        return s[IW-1:0];
    endfunction

    logic [oahs_pkg::KEY_W-1:0] r_slot_mem [TABLE_SLOTS];
    logic [oahs_pkg::KEY_W-1:0] r_rdata;

    t_bstate                        r_state, n_state;
    oahs_pkg::t_action              r_action, n_action;
    logic [oahs_pkg::KEY_W-1:0]     r_key, n_key;
    logic [IW-1:0]                  r_idx, n_idx;
    logic [IW-1:0]                  r_nidx, n_nidx;
    logic [IW-1:0]                  r_sq, n_sq;
    logic [IW-1:0]                  r_odd, n_odd;
    logic [IW-1:0]                  r_cnt, n_cnt;
    logic [CNTW-1:0]                r_live, n_live;
    logic [CNTW-1:0]                r_tomb, n_tomb;
    logic                           r_hit, n_hit;
    logic                           r_full, n_full;
    logic                           r_out_valid, n_out_valid;
    logic [oahs_pkg::OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic                           mem_we;
    logic [oahs_pkg::KEY_W-1:0]     mem_wdata;
    logic                           slot_empty;
    logic                           slot_match;
    logic                           probe_last;
    logic [CNTW:0]                  used_total;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_mem[r_idx] <= mem_wdata;
        end
        r_rdata <= r_slot_mem[r_idx];
    end

    assign o_init_busy = (r_state == B_INIT);
    assign o_tvalid    = r_out_valid;
    assign o_tdata     = r_out_data;
    assign slot_empty  = (r_rdata == '0);
    assign slot_match  = (r_rdata == r_key);
    assign probe_last  = (r_cnt == LAST_IDX);
    assign used_total  = {1'b0, r_live} + {1'b0, r_tomb};

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_key       = r_key;
        n_idx       = r_idx;
        n_nidx      = r_nidx;
        n_sq        = r_sq;
        n_odd       = r_odd;
        n_cnt       = r_cnt;
        n_live      = r_live;
        n_tomb      = r_tomb;
        n_hit       = r_hit;
        n_full      = r_full;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_wdata   = '0;
        o_q_pop     = 1'b0;
        if (i_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            B_INIT, B_SWEEP: begin
                mem_we = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = (r_state == B_INIT) ? B_IDLE : B_DONE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_action = i_q_req.action;
                    n_key    = i_q_req.key;
                    n_idx    = i_q_home;
                    n_sq     = '0;
                    n_odd    = IW'(1);
                    n_cnt    = '0;
                    n_hit    = 1'b0;
                    n_full   = 1'b0;
                    n_state  = B_RD;
                    case (i_q_req.action)
                        oahs_pkg::ACT_CLEAR: begin
                            n_idx   = '0;
                            n_live  = '0;
                            n_tomb  = '0;
                            n_state = B_SWEEP;
                        end
                        oahs_pkg::ACT_ADD: begin
                            if (used_total >= SLOTS_C) begin
                                n_full  = 1'b1;
                                n_state = B_DONE;
                            end
                        end
                        oahs_pkg::ACT_REMOVE: begin
                            if (r_live == '0) begin
                                n_state = B_DONE;
                            end
                        end
                        default: n_state = B_RD;
                    endcase
                end
            end
            B_RD: begin
                n_nidx  = addmod(r_idx, r_sq);
                n_sq    = addmod(r_sq, r_odd);
                n_odd   = addmod(r_odd, IW'(2));
                n_state = B_CHK;
            end
            B_CHK: begin
                n_idx   = r_nidx;
                n_cnt   = r_cnt + IW'(1);
                n_state = B_RD;
                case (r_action)
                    oahs_pkg::ACT_ADD: begin
                        if (slot_empty) begin
                            mem_we    = 1'b1;
                            mem_wdata = r_key;
                            n_idx     = r_idx;
                            n_live    = r_live + CNTW'(1);
                            n_hit     = 1'b1;
                            n_state   = B_DONE;
                        end else if (slot_match) begin
                            n_state = B_DONE;
                        end else if (probe_last) begin
                            n_full  = 1'b1;
                            n_state = B_DONE;
                        end
                    end
                    oahs_pkg::ACT_REMOVE: begin
                        if (slot_match) begin
                            mem_we    = 1'b1;
                            mem_wdata = oahs_pkg::TOMB_MARK;
                            n_idx     = r_idx;
                            n_live    = r_live - CNTW'(1);
                            n_tomb    = r_tomb + CNTW'(1);
                            n_hit     = 1'b1;
                            n_state   = B_DONE;
                        end else if (probe_last) begin
                            n_state = B_DONE;
                        end
                    end
                    oahs_pkg::ACT_CONTAINS: begin
                        if (slot_empty) begin
                            n_state = B_DONE;
                        end else if (slot_match) begin
                            n_hit   = 1'b1;
                            n_state = B_DONE;
                        end else if (probe_last) begin
                            n_state = B_DONE;
                        end
                    end
                    default: n_state = B_DONE;
                endcase
            end
            B_DONE: begin
                if (!r_out_valid || i_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_tomb[oahs_pkg::CNT_OUT_W-1:0],
                                   r_live[oahs_pkg::CNT_OUT_W-1:0],
                                   r_full, r_hit};
                    n_state     = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_INIT;
            r_idx       <= '0;
            r_live      <= '0;
            r_tomb      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_live      <= n_live;
            r_tomb      <= n_tomb;
            r_out_valid <= n_out_valid;
        end
        r_action   <= n_action;
        r_key      <= n_key;
        r_nidx     <= n_nidx;
        r_sq       <= n_sq;
        r_odd      <= n_odd;
        r_cnt      <= n_cnt;
        r_hit      <= n_hit;
        r_full     <= n_full;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

@@ hw/rtl/open_addressing_hash_set_top.sv @@
// ----------------------------------------------------------------------------
// open_addressing_hash_set_top
// Fixed-capacity set of 64-bit keys with tombstones and quadratic probing.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata key, tuser action
// m_axis    out  m_axis_tvalid/tready      tdata hit, full, live, tombstones
// apb       in   psel/penable/pwrite       key substitutes at 0x0 and 0x8
//
// Front end: one request at a time; the home slot is the low key bits when
// TABLE_SLOTS is a power of two, else a remainder taken four key bits a cycle.
// Probe engine: each probe of the single-port slot store has a read state and
// a check state. Clear sweeps the store; after reset the same sweep runs with
// s_axis_tready low.
// A two-entry queue and the output register let either side stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_set_top #(
    parameter int TABLE_SLOTS = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [oahs_pkg::KEY_W-1:0]          s_axis_tdata,  // [63:0] key
    input  wire logic [oahs_pkg::ACT_W-1:0]          s_axis_tuser,  // [1:0] action
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [0] hit, [1] table_full, [12:2] live_count, [23:13] tombstone_count
    output logic [oahs_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [oahs_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [oahs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [oahs_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready
);

    localparam int IW  = $clog2(TABLE_SLOTS);
    localparam int QW  = $bits(oahs_pkg::t_req) + IW;

    logic [oahs_pkg::KEY_W-1:0] r_zero_sub;
    logic [oahs_pkg::KEY_W-1:0] r_mark_sub;
    logic                       cfg_wr;
    logic                       init_busy;
    logic                       f_push;
    oahs_pkg::t_req             f_req;
    logic [IW-1:0]              f_home;
    logic                       q_full;
    logic                       q_valid;
    logic                       q_pop;
    logic [QW-1:0]              q_data;
    oahs_pkg::t_req             q_req;
    logic [IW-1:0]              q_home;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[3] ? r_mark_sub : r_zero_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_sub <= oahs_pkg::ZERO_SUB_DEFAULT;
            r_mark_sub <= oahs_pkg::MARK_SUB_DEFAULT;
        end else if (cfg_wr) begin
            if (paddr[3]) begin
                r_mark_sub <= pwdata;
            end else begin
                r_zero_sub <= pwdata;
            end
        end
    end

    oahs_front #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init_busy (init_busy),
        .i_zero_sub  (r_zero_sub),
        .i_mark_sub  (r_mark_sub),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_key       (s_axis_tdata),
        .i_action    (s_axis_tuser),
        .o_push      (f_push),
        .i_q_full    (q_full),
        .o_req       (f_req),
        .o_home      (f_home)
    );

    oahs_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_req, f_home}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_req  = oahs_pkg::t_req'(q_data[QW-1:IW]);
    assign q_home = q_data[IW-1:0];

    oahs_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_init_busy (init_busy),
        .i_q_valid   (q_valid),
        .i_q_req     (q_req),
        .i_q_home    (q_home),
        .o_q_pop     (q_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ dv/tb_open_addressing_hash_set_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_open_addressing_hash_set_top
// Self-checking bench for the open-addressing hash set with tombstones.
//
// Requests (action and key) go in on the stream input. Each accepted request
// is run through a local model of the slot store, the live count and the
// tombstone count, and the answer it should produce is queued. Every answer
// on the stream output is checked field by field against the oldest queued
// one. Stimulus: a short directed table, mixed traffic on small key pools
// with colliding home slots, and a pass that fills the table to capacity.
// The key substitute registers are rewritten between phases, including the
// out-of-range values that fall back to their defaults. Both sides idle at
// random, and the output is held off once for long enough to back up the
// input.
// ----------------------------------------------------------------------------

module tb_open_addressing_hash_set_top;

    localparam int SLOTS        = 1024;
    localparam int REG_ZERO_SUB = 0;
    localparam int REG_MARK_SUB = 1;

    typedef struct packed {
        logic [oahs_pkg::CNT_OUT_W-1:0] tombs;
        logic [oahs_pkg::CNT_OUT_W-1:0] live;
        logic                           full;
        logic                           hit;
    } t_answer;

    typedef struct {
        oahs_pkg::t_action              act;
        logic [oahs_pkg::KEY_W-1:0]     key;
        bit                             typed;
        logic                           hit;
        logic                           full;
        logic [oahs_pkg::CNT_OUT_W-1:0] live;
        logic [oahs_pkg::CNT_OUT_W-1:0] tombs;
    } t_row;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [oahs_pkg::KEY_W-1:0]       s_axis_tdata  = '0;      // [63:0] key
    logic [oahs_pkg::ACT_W-1:0]       s_axis_tuser  = '0;      // [1:0] action
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // [0] hit, [1] table_full, [12:2] live_count, [23:13] tombstone_count
    logic [oahs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             psel          = 1'b0;
    logic                             penable       = 1'b0;
    logic                             pwrite        = 1'b0;
    logic [oahs_pkg::APB_ADDR_W-1:0]  paddr         = '0;
    logic [oahs_pkg::APB_DATA_W-1:0]  pwdata        = '0;
    logic [oahs_pkg::APB_DATA_W-1:0]  prdata;
    logic                             pready;

    logic [oahs_pkg::KEY_W-1:0] slot_keys [SLOTS] = '{default: '0};
    int unsigned                live_n    = 0;
    int unsigned                tomb_n    = 0;
    logic [oahs_pkg::KEY_W-1:0] zero_sub  = oahs_pkg::ZERO_SUB_DEFAULT;
    logic [oahs_pkg::KEY_W-1:0] mark_sub  = oahs_pkg::MARK_SUB_DEFAULT;

    t_answer answers_due [$];
    bit      failed        = 1'b0;
    int      hold_requests = 0;

    t_row directed_rows [24] = '{
        '{oahs_pkg::ACT_CONTAINS, 64'd0,                   1'b1, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_REMOVE,   64'd5,                   1'b1, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_ADD,      64'd0,                   1'b1, 1'b1, 1'b0, 11'd1, 11'd0},
        '{oahs_pkg::ACT_CONTAINS, 64'd1,                   1'b1, 1'b1, 1'b0, 11'd1, 11'd0},
        '{oahs_pkg::ACT_ADD,      64'd1,                   1'b1, 1'b0, 1'b0, 11'd1, 11'd0},
        '{oahs_pkg::ACT_ADD,      oahs_pkg::TOMB_MARK,     1'b1, 1'b1, 1'b0, 11'd2, 11'd0},
        '{oahs_pkg::ACT_ADD,      64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 1'b0, 11'd3, 11'd0},
        '{oahs_pkg::ACT_ADD,      64'd1025,                1'b0, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_REMOVE,   64'd1,                   1'b0, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_CONTAINS, 64'd1025,                1'b0, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_ADD,      64'd1,                   1'b0, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_REMOVE,   64'd1,                   1'b0, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_REMOVE,   64'd1,                   1'b0, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_CONTAINS, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_ADD,      64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_CONTAINS, oahs_pkg::TOMB_MARK,     1'b0, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_REMOVE,   oahs_pkg::TOMB_MARK,     1'b0, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_REMOVE,   64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_ADD,      64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_ADD,      64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_CLEAR,    64'hffff_ffff_ffff_ffff, 1'b1, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_CONTAINS, 64'd1,                   1'b1, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_REMOVE,   64'd0,                   1'b1, 1'b0, 1'b0, 11'd0, 11'd0},
        '{oahs_pkg::ACT_ADD,      64'd0,                   1'b1, 1'b1, 1'b0, 11'd1, 11'd0}
    };

    open_addressing_hash_set_top #(
        .TABLE_SLOTS (SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [oahs_pkg::KEY_W-1:0] stored_form(
        input logic [oahs_pkg::KEY_W-1:0] raw
    );
        logic [oahs_pkg::KEY_W-1:0] s;
        s = raw;
        if (raw == '0) begin
            s = zero_sub;
            if (s == '0 || s == oahs_pkg::TOMB_MARK) s = oahs_pkg::ZERO_SUB_DEFAULT;
        end else if (raw == oahs_pkg::TOMB_MARK) begin
            s = mark_sub;
            if (s == '0 || s == oahs_pkg::TOMB_MARK) s = oahs_pkg::MARK_SUB_DEFAULT;
        end
        return s;
    endfunction

    function automatic t_answer hash_set_answer(input oahs_pkg::t_action act,
                                                input logic [oahs_pkg::KEY_W-1:0] raw);
        t_answer                    a;
        logic [oahs_pkg::KEY_W-1:0] k;
        int unsigned                idx;
        int unsigned                i;
        bit                         done;
        a    = '0;
        k    = stored_form(raw);
        idx  = 32'(k % SLOTS);
        done = 1'b0;
        case (act)
            oahs_pkg::ACT_ADD: begin
                if (live_n + tomb_n >= SLOTS) begin
                    a.full = 1'b1;
                end else begin
                    for (i = 0; i < SLOTS && !done; i++) begin
                        if (slot_keys[idx] == '0) begin
                            slot_keys[idx] = k;
                            live_n++;
                            a.hit = 1'b1;
                            done  = 1'b1;
                        end else if (slot_keys[idx] == k) begin
                            done = 1'b1;
                        end else begin
                            idx = (idx + i * i) % SLOTS;
                        end
                    end
                    if (!done) a.full = 1'b1;
                end
            end
            oahs_pkg::ACT_REMOVE: begin
                if (live_n != 0) begin
                    for (i = 0; i < SLOTS && !done; i++) begin
                        if (slot_keys[idx] == k) begin
                            slot_keys[idx] = oahs_pkg::TOMB_MARK;
                            live_n--;
                            tomb_n++;
                            a.hit = 1'b1;
                            done  = 1'b1;
                        end else begin
                            idx = (idx + i * i) % SLOTS;
                        end
                    end
                end
            end
            oahs_pkg::ACT_CONTAINS: begin
                for (i = 0; i < SLOTS && !done; i++) begin
                    if (slot_keys[idx] == '0) begin
                        done = 1'b1;
                    end else if (slot_keys[idx] == k) begin
                        a.hit = 1'b1;
                        done  = 1'b1;
                    end else begin
                        idx = (idx + i * i) % SLOTS;
                    end
                end
            end
            default: begin
                foreach (slot_keys[s]) slot_keys[s] = '0;
                live_n = 0;
                tomb_n = 0;
            end
        endcase
        a.live  = live_n[oahs_pkg::CNT_OUT_W-1:0];
        a.tombs = tomb_n[oahs_pkg::CNT_OUT_W-1:0];
        return a;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input oahs_pkg::t_action act,
                                input logic [oahs_pkg::KEY_W-1:0] key,
                                input int gap, input bit typed = 1'b0,
                                input t_answer want = '0);
        t_answer predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = hash_set_answer(act, key);
        answers_due.push_back(typed ? want : predicted);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input int idx, input logic [oahs_pkg::KEY_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= oahs_pkg::APB_ADDR_W'(idx * 8);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_ZERO_SUB) zero_sub = val;
        else mark_sub = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_mixed(input int n_items);
        logic [oahs_pkg::KEY_W-1:0] pool [32];
        logic [oahs_pkg::KEY_W-1:0] key;
        oahs_pkg::t_action          act;
        int                         r;
        int                         j;
        bit                         burst;
        burst = 1'b0;
        for (j = 0; j < 32; j++) begin
            pool[j] = {$urandom, $urandom};
            if (j % 4 == 1) pool[j][9:0] = pool[0][9:0];
        end
        pool[30] = '0;
        pool[31] = oahs_pkg::TOMB_MARK;
        for (j = 0; j < n_items; j++) begin
            if (j % 50 == 0) burst = ($urandom_range(0, 3) == 0);
            if (j == n_items / 2) drain();
            r   = $urandom_range(0, 99);
            key = pool[$urandom_range(0, 31)];
            if (r < 45) act = oahs_pkg::ACT_ADD;
            else if (r < 63) act = oahs_pkg::ACT_REMOVE;
            else if (r < 92) act = oahs_pkg::ACT_CONTAINS;
            else if (r < 94) act = oahs_pkg::ACT_CLEAR;
            else begin
                act = oahs_pkg::t_action'($urandom_range(0, 3));
                key = {$urandom, $urandom};
            end
            send_request(act, key, burst ? 0 : draw_gap());
        end
    endtask

    task automatic run_fill();
        int unsigned                home_order [SLOTS];
        logic [oahs_pkg::KEY_W-1:0] placed [$];
        logic [oahs_pkg::KEY_W-1:0] key;
        oahs_pkg::t_action          act;
        int                         j;
        int                         k;
        int unsigned                tmp;
        for (j = 0; j < SLOTS; j++) home_order[j] = j;
        for (j = SLOTS - 1; j > 0; j--) begin
            k             = $urandom_range(0, j);
            tmp           = home_order[j];
            home_order[j] = home_order[k];
            home_order[k] = tmp;
        end
        send_request(oahs_pkg::ACT_CLEAR, {$urandom, $urandom}, draw_gap());
        // leave one home slot open so that probing can run dry
        for (j = 0; j < SLOTS - 1; j++) begin
            key       = {$urandom, $urandom};
            key[9:0]  = home_order[j][9:0];
            placed.push_back(key);
            send_request(oahs_pkg::ACT_ADD, key, draw_gap());
            if ($urandom_range(0, 24) == 0)
                send_request(oahs_pkg::ACT_CONTAINS,
                             placed[$urandom_range(0, placed.size() - 1)], draw_gap());
        end
        repeat (4) send_request(oahs_pkg::ACT_ADD, {$urandom, $urandom}, draw_gap());
        key      = {$urandom, $urandom};
        key[9:0] = home_order[SLOTS-1][9:0];
        send_request(oahs_pkg::ACT_ADD, key, draw_gap());
        repeat (16) begin
            act = oahs_pkg::t_action'($urandom_range(0, 2));
            key = $urandom_range(0, 2) != 0 ? placed[$urandom_range(0, placed.size() - 1)]
                                            : {$urandom, $urandom};
            send_request(act, key, draw_gap());
        end
    endtask

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_answer'(m_axis_tdata);
            if (answers_due.size() == 0) begin
                failed = 1'b1;
                $display("%0t: answer with no request pending, actual %h", $time,
                         m_axis_tdata);
            end else begin
                want = answers_due.pop_front();
                if (got.hit !== want.hit || got.full !== want.full ||
                    got.live !== want.live || got.tombs !== want.tombs) begin
                    failed = 1'b1;
                    $display("%0t: expected hit=%0b full=%0b live=%0d tombs=%0d, %s",
                             $time, want.hit, want.full, want.live, want.tombs,
                             $sformatf("actual hit=%0b full=%0b live=%0d tombs=%0d",
                                       got.hit, got.full, got.live, got.tombs));
                end
            end
        end
    end

    initial begin
        int run_len;
        int stall;
        int holds_served;
        holds_served = 0;
        @(posedge i_clk);
        forever begin
            if (hold_requests > holds_served) begin
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
                                                      : $urandom_range(1, 8);
                repeat (run_len) @(posedge i_clk);
                stall = draw_gap();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_request(directed_rows[r].act, directed_rows[r].key, draw_gap(),
                         directed_rows[r].typed,
                         '{tombs: directed_rows[r].tombs, live: directed_rows[r].live,
                           full: directed_rows[r].full, hit: directed_rows[r].hit});
        drain();

        write_reg(REG_ZERO_SUB, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_MARK_SUB, 64'd1);
        hold_requests = 1;
        run_mixed(470);
        drain();

        // out-of-range substitutes fall back to their defaults
        write_reg(REG_ZERO_SUB, 64'd0);
        write_reg(REG_MARK_SUB, oahs_pkg::TOMB_MARK);
        run_fill();
        drain();

        write_reg(REG_ZERO_SUB, oahs_pkg::TOMB_MARK);
        write_reg(REG_MARK_SUB, 64'd0);
        run_mixed(200);
        drain();

        write_reg(REG_ZERO_SUB, {$urandom, $urandom});
        write_reg(REG_MARK_SUB, {$urandom, $urandom});
        run_mixed(200);
        drain();

        repeat (50) @(posedge i_clk);
        if (!failed) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
